FILE: design/assert_macros.svh
// Assertion helpers shared by the allocator RTL.
// Each macro expands to one labeled concurrent assertion on clk_i / rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property every clock while out of reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle
`define ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: design/bpfa_pkg.sv
// Shared types and constants of the bitmap page frame allocator.
// No dependencies.
package bpfa_pkg;

  localparam int unsigned MapWordsDefault  = 1024;
  localparam int unsigned PageBytesDefault = 4096;
  localparam int unsigned AddrW            = 48;
  localparam logic [10:0] WiuReset         = 11'd1024;
  localparam logic [63:0] FullWord         = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef enum logic [2:0] {
    CMD_ALLOC_ONE  = 3'd0,
    CMD_ALLOC_RUN  = 3'd1,
    CMD_FREE_FRAME = 3'd2,
    CMD_LOCK_FRAME = 3'd3,
    CMD_FREE_RANGE = 3'd4,
    CMD_LOCK_RANGE = 3'd5
  } cmd_e;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [47:0] base_address;
    logic [47:0] length_bytes;
    logic [16:0] frame_count;
  } cmd_t;

  typedef struct packed {
    logic        status;
    logic [47:0] granted_address;
  } res_t;

endpackage

FILE: design/bitmap_page_frame_allocator.sv
// Top level of the bitmap page frame allocator: word count register and
// active-word clamp around the sequencer. Depends on bpfa_pkg and bpfa_engine.
//
//   channel   signals                               direction
//   command   start, busy, cmd_i                    in  (taken when start & !busy)
//   result    done_o, res_o                         out (one-cycle strobe, no stall)
//   config    cfg_valid_i, cfg_ready_o, cfg_data_i  in  (words_in_use)
//
// After reset a clearing pass locks every frame; busy is high. A frame or range
// command passes the prep and clamp states, then reads and writes each bitmap word
// it covers; an alloc reads each word scanned, up to the active word count. Alloc
// run walks a partly used word frame by frame, and on success rewrites each word
// of the run it locks. Accepted commands run one at a time through the map memory.
// The result strobe lasts one cycle and cannot stall; busy drops with it.
module bitmap_page_frame_allocator #(
  parameter int unsigned MAP_WORDS  = bpfa_pkg::MapWordsDefault,
  parameter int unsigned PAGE_BYTES = bpfa_pkg::PageBytesDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  bpfa_pkg::cmd_t cmd_i,
  output logic           done_o,
  output bpfa_pkg::res_t res_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [10:0]    cfg_data_i
);
  import bpfa_pkg::*;

  localparam int unsigned AWW = $clog2(MAP_WORDS + 1);

  logic [10:0]    wiu_q;
  logic [AWW-1:0] active_words;

  // Hold the word count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wiu_q <= WiuReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      wiu_q <= cfg_data_i;
    end
  end

  assign cfg_ready_o = 1'b1;

  // Saturate the word count at the map depth
  assign active_words = (32'(wiu_q) > 32'(MAP_WORDS)) ? AWW'(MAP_WORDS) : AWW'(wiu_q);

  bpfa_engine #(.MAP_WORDS(MAP_WORDS), .PAGE_BYTES(PAGE_BYTES), .AWW(AWW)) u_engine (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .active_words_i (active_words),
    .start          (start),
    .cmd_i          (cmd_i),
    .busy           (busy),
    .done_o         (done_o),
    .res_o          (res_o)
  );

endmodule

FILE: design/bpfa_map_ram.sv
// Frame bitmap storage: one write port, one read port, registered read data.
// Depends on nothing.
module bpfa_map_ram #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned AW    = 10
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [63:0]   wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [63:0]   rdata_o
);

  logic [63:0] mem_q [Depth];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

FILE: design/bpfa_engine.sv
// Command sequencer: clears the map after reset, then walks bitmap words by
// read-modify-write. Depends on bpfa_pkg, bpfa_map_ram and assert_macros.svh.
`include "assert_macros.svh"
module bpfa_engine #(
  parameter int unsigned MAP_WORDS  = bpfa_pkg::MapWordsDefault,
  parameter int unsigned PAGE_BYTES = bpfa_pkg::PageBytesDefault,
  parameter int unsigned AWW        = $clog2(MAP_WORDS + 1)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [AWW-1:0] active_words_i,
  input  logic           start,
  input  bpfa_pkg::cmd_t cmd_i,
  output logic           busy,
  output logic           done_o,
  output bpfa_pkg::res_t res_o
);
  import bpfa_pkg::*;

  localparam int unsigned AWID  = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned SHIFT = $clog2(PAGE_BYTES);
  localparam int unsigned FW    = 50 - SHIFT;
  localparam int unsigned LW    = AWW + 6;

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_PREP, S_CLAMP, S_RD, S_EX, S_BIT
  } state_e;

  typedef enum logic [1:0] {M_SET, M_ONE, M_RUN} mode_e;

  state_e          state_q;
  mode_e           mode_q;
  cmd_t            req_q;
  logic [AWID-1:0] init_q;
  logic [FW-1:0]   first_q, end_q;
  logic [AWW-1:0]  widx_q;
  logic [16:0]     run_q;
  logic [5:0]      bit_q;
  logic [63:0]     word_q;
  logic            lock_q;
  logic [47:0]     addr_q;
  logic            done_q;
  res_t            res_q;

  // Memory port signals
  logic            we, re;
  logic [AWID-1:0] waddr, raddr;
  logic [63:0]     wdata, rdata;

  bpfa_map_ram #(.Depth(MAP_WORDS), .AW(AWID)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Lowest clear bit of a word
  function automatic logic [5:0] low_zero(input logic [63:0] w);
    logic [5:0] p;
    p = '0;
    for (int i = 63; i >= 0; i--) begin
      if (!w[i]) p = 6'(i);
    end
    return p;
  endfunction

  // Frame arithmetic
  logic [49:0]    sum_up, sum_end, sum_end_up;
  logic [LW-1:0]  limit;
  logic [FW-1:0]  end_clamp, end_m1;
  logic [AWW-1:0] last_word, first_word, widx_inc;
  logic [5:0]     lo, hi, zpos;
  logic [63:0]    mask;
  logic           wlast;
  logic [17:0]    run_w64;
  logic [LW-1:0]  f_zero, f_bit, f_hit, first_hit;

  assign sum_up     = {2'b0, req_q.base_address} + 50'(PAGE_BYTES - 1);
  assign sum_end    = {2'b0, req_q.base_address} + {2'b0, req_q.length_bytes};
  assign sum_end_up = sum_end + 50'(PAGE_BYTES - 1);
  assign limit      = {active_words_i, 6'b0};
  assign end_clamp  = (end_q > FW'(limit)) ? FW'(limit) : end_q;
  assign end_m1     = end_q - FW'(1);
  assign last_word  = AWW'(end_m1 >> 6);
  assign first_word = AWW'(first_q >> 6);
  assign widx_inc   = widx_q + AWW'(1);
  assign wlast      = (widx_inc == active_words_i);
  assign lo         = (widx_q == first_word) ? first_q[5:0] : 6'd0;
  assign hi         = (widx_q == last_word) ? end_m1[5:0] : 6'd63;
  assign mask       = (FullWord << lo) & (FullWord >> (6'd63 - hi));
  assign zpos       = low_zero(rdata);
  assign run_w64    = {1'b0, run_q} + 18'd64;
  assign f_zero     = {widx_q, 6'b0} + LW'(req_q.frame_count - run_q - 17'd1);
  assign f_bit      = {widx_q, bit_q};
  assign f_hit      = (state_q == S_BIT) ? f_bit : f_zero;
  assign first_hit  = f_hit + LW'(1) - LW'(req_q.frame_count);

  // Memory access by state
  always_comb begin
    we    = 1'b0;
    waddr = widx_q[AWID-1:0];
    wdata = rdata;
    re    = (state_q == S_RD);
    raddr = widx_q[AWID-1:0];
    unique case (state_q)
      S_INIT: begin
        we    = 1'b1;
        waddr = init_q;
        wdata = FullWord;
      end
      S_EX: begin
        unique case (mode_q)
          M_SET: begin
            we    = 1'b1;
            wdata = lock_q ? (rdata | mask) : (rdata & ~mask);
          end
          M_ONE: begin
            we    = (rdata != FullWord);
            wdata = rdata | (64'd1 << zpos);
          end
          default: we = 1'b0;
        endcase
      end
      default: we = 1'b0;
    endcase
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      mode_q  <= M_SET;
      init_q  <= '0;
      done_q  <= 1'b0;
      widx_q  <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_INIT: begin
          init_q <= init_q + AWID'(1);
          if (init_q == AWID'(MAP_WORDS - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            req_q   <= cmd_i;
            state_q <= S_PREP;
          end
        end
        S_PREP: begin
          widx_q <= '0;
          run_q  <= '0;
          addr_q <= '0;
          priority case (cmd_e'(req_q.cmd))
            CMD_ALLOC_ONE: begin
              mode_q <= M_ONE;
              if (active_words_i == '0) begin
                res_q   <= '{status: 1'b1, granted_address: '0};
                done_q  <= 1'b1;
                state_q <= S_IDLE;
              end else state_q <= S_RD;
            end
            CMD_ALLOC_RUN: begin
              mode_q <= M_RUN;
              if (active_words_i == '0 || req_q.frame_count == '0) begin
                res_q   <= '{status: 1'b1, granted_address: '0};
                done_q  <= 1'b1;
                state_q <= S_IDLE;
              end else state_q <= S_RD;
            end
            CMD_FREE_FRAME, CMD_LOCK_FRAME: begin
              first_q <= FW'(req_q.base_address >> SHIFT);
              end_q   <= FW'(req_q.base_address >> SHIFT) + FW'(1);
              lock_q  <= (cmd_e'(req_q.cmd) == CMD_LOCK_FRAME);
              state_q <= S_CLAMP;
            end
            CMD_FREE_RANGE: begin
              first_q <= FW'(sum_up >> SHIFT);
              end_q   <= FW'(sum_end >> SHIFT);
              lock_q  <= 1'b0;
              state_q <= S_CLAMP;
            end
            CMD_LOCK_RANGE: begin
              first_q <= FW'(sum_up >> SHIFT);
              end_q   <= FW'(sum_end_up >> SHIFT);
              lock_q  <= 1'b1;
              state_q <= S_CLAMP;
            end
            default: begin
              res_q   <= '{status: 1'b1, granted_address: '0};
              done_q  <= 1'b1;
              state_q <= S_IDLE;
            end
          endcase
        end
        S_CLAMP: begin
          // Drop frames past the active map; empty ranges finish at once
          if (first_q >= end_clamp) begin
            res_q   <= '{status: 1'b0, granted_address: addr_q};
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end else begin
            end_q   <= end_clamp;
            widx_q  <= first_word;
            mode_q  <= M_SET;
            state_q <= S_RD;
          end
        end
        S_RD: state_q <= S_EX;
        S_EX: begin
          unique case (mode_q)
            M_SET: begin
              if (widx_q == last_word) begin
                res_q   <= '{status: 1'b0, granted_address: addr_q};
                done_q  <= 1'b1;
                state_q <= S_IDLE;
              end else begin
                widx_q  <= widx_inc;
                state_q <= S_RD;
              end
            end
            M_ONE: begin
              if (rdata != FullWord) begin
                res_q   <= '{status: 1'b0,
                            granted_address: 48'({widx_q, zpos, {SHIFT{1'b0}}})};
                done_q  <= 1'b1;
                state_q <= S_IDLE;
              end else if (wlast) begin
                res_q   <= '{status: 1'b1, granted_address: '0};
                done_q  <= 1'b1;
                state_q <= S_IDLE;
              end else begin
                widx_q  <= widx_inc;
                state_q <= S_RD;
              end
            end
            default: begin
              if (rdata == '0 && run_w64 >= {1'b0, req_q.frame_count}) begin
                // Run completes inside a free word: lock it
                first_q <= FW'(first_hit);
                end_q   <= FW'(f_hit) + FW'(1);
                addr_q  <= 48'({first_hit, {SHIFT{1'b0}}});
                lock_q  <= 1'b1;
                mode_q  <= M_SET;
                widx_q  <= AWW'(first_hit >> 6);
                state_q <= S_RD;
              end else if (rdata == '0 || rdata == FullWord) begin
                run_q <= (rdata == '0) ? 17'(run_w64) : '0;
                if (wlast) begin
                  res_q   <= '{status: 1'b1, granted_address: '0};
                  done_q  <= 1'b1;
                  state_q <= S_IDLE;
                end else begin
                  widx_q  <= widx_inc;
                  state_q <= S_RD;
                end
              end else begin
                word_q  <= rdata;
                bit_q   <= '0;
                state_q <= S_BIT;
              end
            end
          endcase
        end
        S_BIT: begin
          // Walk a mixed word one frame per cycle
          if (!word_q[bit_q] && (run_q + 17'd1 == req_q.frame_count)) begin
            first_q <= FW'(first_hit);
            end_q   <= FW'(f_hit) + FW'(1);
            addr_q  <= 48'({first_hit, {SHIFT{1'b0}}});
            lock_q  <= 1'b1;
            mode_q  <= M_SET;
            widx_q  <= AWW'(first_hit >> 6);
            state_q <= S_RD;
          end else begin
            run_q <= word_q[bit_q] ? '0 : run_q + 17'd1;
            bit_q <= bit_q + 6'd1;
            if (bit_q == 6'd63) begin
              if (wlast) begin
                res_q   <= '{status: 1'b1, granted_address: '0};
                done_q  <= 1'b1;
                state_q <= S_IDLE;
              end else begin
                widx_q  <= widx_inc;
                state_q <= S_RD;
              end
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

  `ASSERT_CLK(a_done_after_busy, done_o |-> $past(busy), "result without a command in flight")
  `ASSERT_IMP(a_init_fill, state_q == S_INIT, wdata == FullWord, "clearing pass must lock")
  `ASSERT_IMP(a_idle_no_write, !busy, !we, "map written while idle")
  `ASSERT_IMP(a_no_rw_same_cycle, we && re, 1'b0, "read and write issued together")

endmodule

FILE: tb/bitmap_page_frame_allocator_test.sv
// Self-checking testbench for bitmap_page_frame_allocator: a directed table and then
// random command phases, checked against table values or an in-bench frame map predictor.
// Depends on bpfa_pkg and the allocator RTL.
module bitmap_page_frame_allocator_test;
  import bpfa_pkg::*;

  localparam int unsigned     PageSz     = 4096;
  localparam int unsigned     MapSz      = 1024;
  localparam longint unsigned CycleLimit = 250_000_000;
  localparam logic [2:0]      CmdBadLo   = 3'd6;
  localparam logic [2:0]      CmdBadHi   = 3'd7;
  localparam logic [47:0]     AddrMax    = 48'hFFFF_FFFF_FFFF;

  typedef struct {
    cmd_t c;
    bit   typed;
    res_t want;
  } row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  cmd_t        cmd_i;
  logic        done_o;
  res_t        res_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [10:0] cfg_data_i;

  // Predictor state: frame map and word count register
  logic [63:0]     frame_bits [MapSz];
  logic [10:0]     words_cfg;
  res_t            grant_q [$];
  res_t            want_r;
  row_t            rows [$];
  int unsigned     mismatch_count;
  int unsigned     item_count;
  int unsigned     sender_idle_pct;
  longint unsigned cycles;

  bitmap_page_frame_allocator uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .cmd_i      (cmd_i),
    .done_o     (done_o),
    .res_o      (res_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint unsigned live_frames();
    longint unsigned w;
    w = 64'((words_cfg > MapSz) ? MapSz : 32'(words_cfg));
    return w * 64;
  endfunction

  function automatic void mark_frame(longint unsigned f, bit lock);
    if (f >= live_frames()) return;
    frame_bits[f / 64][f % 64] = lock;
  endfunction

  function automatic void mark_span(longint unsigned first, longint unsigned last, bit lock);
    longint unsigned lim;
    lim = live_frames();
    if (last > lim) last = lim;
    for (longint unsigned f = first; f < last; f++) mark_frame(f, lock);
  endfunction

  // Work out the grant for one command and update the frame map
  function automatic res_t predict_grant(cmd_t c);
    longint unsigned base, len, cnt, total, addr, run, first;
    res_t            r;
    bit              st;
    base  = 64'(c.base_address);
    len   = 64'(c.length_bytes);
    cnt   = 64'(c.frame_count);
    total = live_frames();
    addr  = 0;
    st    = 1'b0;
    case (c.cmd)
      CMD_ALLOC_ONE: begin
        st = 1'b1;
        for (longint unsigned f = 0; f < total; f++) begin
          if ((f % 64) == 0 && frame_bits[f / 64] == FullWord) begin
            f += 63;
            continue;
          end
          if (!frame_bits[f / 64][f % 64]) begin
            mark_frame(f, 1'b1);
            addr = f * PageSz;
            st   = 1'b0;
            break;
          end
        end
      end
      CMD_ALLOC_RUN: begin
        st  = 1'b1;
        run = 0;
        if (cnt != 0) begin
          for (longint unsigned f = 0; f < total; f++) begin
            if (frame_bits[f / 64][f % 64]) begin
              run = 0;
              continue;
            end
            run++;
            if (run == cnt) begin
              first = f + 1 - cnt;
              mark_span(first, f + 1, 1'b1);
              addr = first * PageSz;
              st   = 1'b0;
              break;
            end
          end
        end
      end
      CMD_FREE_FRAME, CMD_LOCK_FRAME: mark_frame(base / PageSz, c.cmd == CMD_LOCK_FRAME);
      CMD_FREE_RANGE: mark_span((base + PageSz - 1) / PageSz, (base + len) / PageSz, 1'b0);
      CMD_LOCK_RANGE:
        mark_span((base + PageSz - 1) / PageSz, (base + len + PageSz - 1) / PageSz, 1'b1);
      default: st = 1'b1;
    endcase
    r.status          = st;
    r.granted_address = addr[47:0];
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("ERROR cycle %0d: %s", cycles, msg);
    mismatch_count++;
  endtask

  // Drive one command and record its expected grant once accepted
  task automatic send_cmd(cmd_t c, bit typed, res_t want);
    res_t p;
    while ($urandom_range(99) < sender_idle_pct) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
    @(negedge clk_i);
    start <= 1'b1;
    cmd_i <= c;
    do @(posedge clk_i); while (busy);
    p = predict_grant(c);
    grant_q.push_back(typed ? want : p);
    item_count++;
  endtask

  // Write the word count register while the block is quiet
  task automatic write_words(logic [10:0] v);
    @(negedge clk_i);
    start <= 1'b0;
    wait (grant_q.size() == 0);
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    words_cfg = v;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic void add_row(logic [2:0] op, logic [47:0] b, logic [47:0] l,
                                  logic [16:0] n, bit typed, bit st, logic [47:0] a);
    row_t r;
    r.c                    = '{cmd: op, base_address: b, length_bytes: l, frame_count: n};
    r.typed                = typed;
    r.want.status          = st;
    r.want.granted_address = a;
    rows.push_back(r);
  endfunction

  function automatic logic [47:0] rand48();
    return 48'({$urandom, $urandom});
  endfunction

  // Random command, mostly aimed inside the active frames
  function automatic cmd_t random_cmd();
    cmd_t        c;
    int unsigned fr, pick;
    fr   = 32'((live_frames() < 64) ? 64 : live_frames());
    pick = $urandom_range(99);
    if (pick < 20)      c.cmd = CMD_ALLOC_ONE;
    else if (pick < 35) c.cmd = CMD_ALLOC_RUN;
    else if (pick < 50) c.cmd = CMD_FREE_FRAME;
    else if (pick < 60) c.cmd = CMD_LOCK_FRAME;
    else if (pick < 78) c.cmd = CMD_FREE_RANGE;
    else if (pick < 96) c.cmd = CMD_LOCK_RANGE;
    else                c.cmd = $urandom_range(1) ? CmdBadLo : CmdBadHi;
    c.base_address = ($urandom_range(99) < 80) ?
                     48'($urandom_range(fr * PageSz + 8192)) : rand48();
    pick = $urandom_range(99);
    if (pick < 10)      c.length_bytes = '0;
    else if (pick < 80) c.length_bytes = 48'($urandom_range(fr * PageSz / 4));
    else                c.length_bytes = rand48();
    pick = $urandom_range(99);
    if (pick < 10)      c.frame_count = '0;
    else if (pick < 20) c.frame_count = 17'($urandom);
    else if (pick < 60) c.frame_count = 17'($urandom_range(1, 8));
    else                c.frame_count = 17'($urandom_range(1, fr / 4));
    return c;
  endfunction

  // Compare each result strobe with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (grant_q.size() == 0) begin
        report_mismatch("result strobe with no command pending");
      end else begin
        want_r = grant_q.pop_front();
        if (res_o.status !== want_r.status)
          report_mismatch($sformatf("status %b, want %b", res_o.status, want_r.status));
        if (res_o.granted_address !== want_r.granted_address)
          report_mismatch($sformatf("granted_address %h, want %h",
                                    res_o.granted_address, want_r.granted_address));
      end
    end
  end

  // Hard stop on a hang
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, grant_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int unsigned phase_words [12] = '{4, 2047, 1, 8, 0, 3, 16, 1024, 2, 6, 11, 64};
    int unsigned phase_items [12] = '{60, 12, 60, 60, 30, 60, 60, 12, 60, 60, 60, 12};
    res_t        none;
    none            = '0;
    cycles          = 0;
    mismatch_count  = 0;
    item_count      = 0;
    sender_idle_pct = 0;
    words_cfg       = WiuReset;
    for (int i = 0; i < MapSz; i++) frame_bits[i] = FullWord;
    rst_ni      = 1'b0;
    start       = 1'b0;
    cmd_i       = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed table over the full map, which starts fully locked
    add_row(CMD_ALLOC_ONE, '0, '0, '0, 1, 1'b1, '0);
    add_row(CMD_ALLOC_RUN, '0, '0, '0, 1, 1'b1, '0);
    add_row(CmdBadLo, AddrMax, AddrMax, '1, 1, 1'b1, '0);
    add_row(CmdBadHi, '0, '0, 17'd1, 1, 1'b1, '0);
    add_row(CMD_FREE_FRAME, 48'd100, '0, '0, 1, 1'b0, '0);
    add_row(CMD_ALLOC_ONE, '0, '0, '0, 1, 1'b0, '0);
    add_row(CMD_FREE_RANGE, 48'd1, 48'd8191, '0, 1, 1'b0, '0);
    add_row(CMD_ALLOC_RUN, '0, '0, 17'd1, 1, 1'b0, 48'd4096);
    add_row(CMD_FREE_FRAME, AddrMax, '0, '0, 1, 1'b0, '0);
    add_row(CMD_FREE_RANGE, '0, AddrMax, '0, 1, 1'b0, '0);
    add_row(CMD_ALLOC_RUN, '0, '0, 17'd65536, 1, 1'b0, '0);
    add_row(CMD_ALLOC_ONE, '0, '0, '0, 1, 1'b1, '0);
    add_row(CMD_FREE_RANGE, '0, 48'd524288, '0, 0, 1'b0, '0);
    add_row(CMD_LOCK_RANGE, 48'd1, 48'd1, '0, 0, 1'b0, '0);
    add_row(CMD_LOCK_RANGE, 48'd4095, 48'd2, '0, 0, 1'b0, '0);
    add_row(CMD_ALLOC_RUN, '0, '0, 17'd2, 0, 1'b0, '0);
    add_row(CMD_ALLOC_RUN, '0, '0, '1, 1, 1'b1, '0);
    add_row(CMD_FREE_RANGE, 48'd8192, '0, '0, 1, 1'b0, '0);
    add_row(CMD_LOCK_FRAME, 48'd40960, AddrMax, '1, 0, 1'b0, '0);
    add_row(CMD_ALLOC_ONE, '0, '0, '0, 0, 1'b0, '0);
    add_row(CMD_FREE_RANGE, AddrMax, AddrMax, '0, 1, 1'b0, '0);
    add_row(CMD_LOCK_RANGE, AddrMax, AddrMax, '0, 1, 1'b0, '0);
    add_row(CMD_ALLOC_RUN, '0, '0, 17'd127, 0, 1'b0, '0);

    write_words(11'd1024);
    foreach (rows[i]) send_cmd(rows[i].c, rows[i].typed, rows[i].want);

    // Random phases: each third of them uses a different sender idle rate
    for (int p = 0; p < 12; p++) begin
      write_words(11'(phase_words[p]));
      case (p / 4)
        0:       sender_idle_pct = 38;
        1:       sender_idle_pct = 83;
        default: sender_idle_pct = 0;
      endcase
      for (int n = 0; n < phase_items[p]; n++) send_cmd(random_cmd(), 0, none);
    end

    // Drain and let the block settle
    @(negedge clk_i);
    start <= 1'b0;
    wait (grant_q.size() == 0);
    repeat (20) @(posedge clk_i);

    $display("Ran %0d commands over 13 word count writes, including zero and oversized,",
             item_count);
    $display("with directed edge cases and three sender idle rates; %0d errors.",
             mismatch_count);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
